FILE: hdl/obm_pkg.sv
// ----------------------------------------------------------------------------
// obm_pkg: shared types and constants for the order book matcher
// Request and result payloads, function and result codes, book entry type.
// ----------------------------------------------------------------------------
package obm_pkg;

  localparam int SIDE_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    FN_SUBMIT = 2'd0,
    FN_QUERY  = 2'd1,
    FN_CANCEL = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    K_ID     = 3'd0,
    K_DEAL   = 3'd1,
    K_LBUY   = 3'd2,
    K_LSELL  = 3'd3,
    K_CANCEL = 3'd4,
    K_NOTFND = 3'd5,
    K_FULL   = 3'd6
  } kind_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [13:0] stock_code;
    logic [15:0] limit_price;
    logic [15:0] order_qty;
    logic        is_sell;
    logic [15:0] cancel_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] order_id;
    logic [15:0] other_id;
    logic [13:0] code_out;
    logic [16:0] price_twice;
    logic [15:0] qty_out;
    logic        side_out;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [13:0] code;
    logic [15:0] price;
    logic [15:0] qty;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IDOUT,
    S_MATCH,
    S_FULL,
    S_INS,
    S_QBUY,
    S_QSELL,
    S_CBUY,
    S_CSELL,
    S_CNF
  } st_t;

endpackage

FILE: hdl/obm_front.sv
// ----------------------------------------------------------------------------
// obm_front: request intake
// Two-entry queue that takes requests, drops unused function codes.
// ----------------------------------------------------------------------------
module obm_front import obm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic q_valid,
  input  logic q_ready,
  output req_t q_req
);

  req_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_ready = (cnt != 2'd2);
  // unused function code is swallowed here
  assign push     = in_valid && in_ready && (in_req.func != FN_NONE);
  assign q_valid  = (cnt != 2'd0);
  assign q_req    = mem[rp];
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_req;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hdl/obm_back.sv
// ----------------------------------------------------------------------------
// obm_back: book engine
// Sequencer that matches, inserts, lists and cancels, one book slot a cycle while the output is not busy.
// ----------------------------------------------------------------------------
module obm_back import obm_pkg::*; #(
  parameter int SIDE_DEPTH = SIDE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  req_t q_req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int IW = $clog2(SIDE_DEPTH);
  localparam int CW = $clog2(SIDE_DEPTH + 1);

  slot_t book [2][SIDE_DEPTH];
  logic [CW-1:0] cnt [2];
  logic [15:0] next_id;

  st_t st, st_next;
  req_t rq;
  logic [15:0] id, rem;
  logic [CW-1:0] idx;
  logic dpend; // a result of the current request is held, last undecided

  // output register
  res_t ob;
  logic ob_v;
  logic ob_free;
  assign ob_free = !ob_v || res_ready;
  assign res_valid = ob_v;
  assign res = ob;

  logic side, opp;
  assign side = rq.is_sell;
  assign opp  = ~rq.is_sell;

  slot_t e;
  logic [IW-1:0] ix;
  assign ix = idx[IW-1:0];

  logic [CW-1:0] ecnt;
  logic          ebook;
  always_comb begin
    ebook = 1'b0;
    case (st)
      S_MATCH: ebook = opp;
      S_INS:   ebook = side;
      S_QSELL, S_CSELL: ebook = 1'b1;
      default: ebook = 1'b0;
    endcase
    ecnt = cnt[ebook];
    e = book[ebook][ix];
  end

  logic inb;
  assign inb = idx < ecnt;

  logic pok;
  logic [15:0] fq;
  assign pok = side ? (e.price >= rq.limit_price) : (e.price <= rq.limit_price);
  assign fq  = (e.qty < rem) ? e.qty : rem;

  // emission: pending result register, shown when next one or end decides last
  res_t pend;
  res_t nr;
  logic emit, fin;

  logic ins_here;
  assign ins_here = !inb || (side ? (rq.limit_price < e.price)
                                  : (rq.limit_price > e.price));

  always_comb begin
    st_next = st;
    emit = 1'b0;
    fin  = 1'b0;
    nr   = '0;
    q_ready = 1'b0;
    case (st)
      S_IDLE: begin
        // the previous request's final result must leave before a new one starts
        q_ready = !dpend || ob_free;
        if (q_valid && q_ready) begin
          case (q_req.func)
            FN_SUBMIT: st_next = S_IDOUT;
            FN_QUERY:  st_next = S_QBUY;
            default:   st_next = S_CBUY;
          endcase
        end
      end
      S_IDOUT: begin
        emit = 1'b1;
        nr.kind = K_ID; nr.order_id = id; nr.code_out = rq.stock_code;
        nr.price_twice = {rq.limit_price, 1'b0}; nr.qty_out = rq.order_qty;
        nr.side_out = side;
        st_next = S_MATCH;
      end
      S_MATCH: begin
        if (rem == 16'd0 || !inb) begin
          if (rem == 16'd0) begin fin = 1'b1; st_next = S_IDLE; end
          else if (cnt[side] < CW'(SIDE_DEPTH)) st_next = S_INS;
          else st_next = S_FULL;
        end else if (e.code == rq.stock_code && pok) begin
          emit = 1'b1;
          nr.kind = K_DEAL;
          nr.order_id = side ? e.id : id;
          nr.other_id = side ? id : e.id;
          nr.code_out = rq.stock_code;
          nr.price_twice = {1'b0, e.price} + {1'b0, rq.limit_price};
          nr.qty_out = fq;
        end
      end
      S_FULL: begin
        emit = 1'b1; fin = 1'b1;
        nr.kind = K_FULL; nr.order_id = id; nr.code_out = rq.stock_code;
        nr.price_twice = {rq.limit_price, 1'b0}; nr.qty_out = rem;
        nr.side_out = side;
        st_next = S_IDLE;
      end
      S_INS: begin
        if (ins_here) begin fin = 1'b1; st_next = S_IDLE; end
      end
      S_QBUY, S_QSELL: begin
        if (!inb) begin
          if (st == S_QBUY) st_next = S_QSELL;
          else begin fin = 1'b1; st_next = S_IDLE; end
        end else if (e.code == rq.stock_code) begin
          emit = 1'b1;
          nr.kind = (st == S_QBUY) ? K_LBUY : K_LSELL;
          nr.order_id = e.id; nr.code_out = e.code;
          nr.price_twice = {e.price, 1'b0}; nr.qty_out = e.qty;
          nr.side_out = (st == S_QSELL);
        end
      end
      S_CBUY, S_CSELL: begin
        if (!inb) st_next = (st == S_CBUY) ? S_CSELL : S_CNF;
        else if (e.id == rq.cancel_id) begin
          emit = 1'b1; fin = 1'b1;
          nr.kind = K_CANCEL; nr.order_id = e.id; nr.code_out = e.code;
          nr.price_twice = {e.price, 1'b0}; nr.qty_out = e.qty;
          nr.side_out = (st == S_CSELL);
          st_next = S_IDLE;
        end
      end
      S_CNF: begin
        emit = 1'b1; fin = 1'b1;
        nr.kind = K_NOTFND; nr.order_id = rq.cancel_id;
        st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  // work stalls when it must push the pending result and the output is busy
  logic need_push, go;
  assign need_push = dpend && (emit || fin);
  assign go = (st == S_IDLE) || !need_push || ob_free;

  // push: held result leaves as a new one replaces it or the request ends
  // flush: final result still held at idle leaves with last set
  logic do_push, do_flush;
  assign do_push  = go && need_push;
  assign do_flush = (st == S_IDLE) && dpend && ob_free;

  res_t push_r, flush_r;
  always_comb begin
    push_r = pend;
    push_r.last = fin && !emit;
    flush_r = pend;
    flush_r.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; dpend <= 1'b0; ob_v <= 1'b0; next_id <= 16'd0;
      cnt[0] <= '0; cnt[1] <= '0;
    end else begin
      if (do_push) begin
        ob <= push_r; ob_v <= 1'b1;
      end else if (do_flush) begin
        ob <= flush_r; ob_v <= 1'b1;
      end else if (res_ready) ob_v <= 1'b0;
      if (do_flush) dpend <= 1'b0;
      else if (go && emit) dpend <= 1'b1;
      else if (go && fin) dpend <= 1'b0;
      if (go && emit) pend <= nr;
      if (go) begin
        st <= st_next;
        case (st)
          S_IDLE: if (q_valid && q_ready) begin
            rq <= q_req; rem <= q_req.order_qty; idx <= '0;
            id <= (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
            if (q_req.func == FN_SUBMIT)
              next_id <= (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
          end
          S_MATCH: begin
            if (rem != 16'd0 && inb && e.code == rq.stock_code && pok) begin
              rem <= rem - fq;
              if (e.qty == fq) begin
                for (int k = 0; k < SIDE_DEPTH - 1; k++)
                  if (CW'(k) >= idx) book[opp][k] <= book[opp][k+1];
                cnt[opp] <= cnt[opp] - CW'(1);
              end else begin
                book[opp][ix].qty <= e.qty - fq;
                idx <= idx + CW'(1);
              end
            end else if (rem != 16'd0 && inb) idx <= idx + CW'(1);
            else idx <= '0;
          end
          S_INS: begin
            if (ins_here) begin
              for (int k = 1; k < SIDE_DEPTH; k++)
                if (CW'(k) > idx) book[side][k] <= book[side][k-1];
              book[side][ix] <= '{id: id, code: rq.stock_code,
                                  price: rq.limit_price, qty: rem};
              cnt[side] <= cnt[side] + CW'(1);
            end else idx <= idx + CW'(1);
          end
          S_QBUY, S_QSELL, S_CBUY, S_CSELL: begin
            if (!inb) idx <= '0;
            else if ((st == S_CBUY || st == S_CSELL) && e.id == rq.cancel_id) begin
              for (int k = 0; k < SIDE_DEPTH - 1; k++)
                if (CW'(k) >= idx) book[ebook][k] <= book[ebook][k+1];
              cnt[ebook] <= cnt[ebook] - CW'(1);
            end else idx <= idx + CW'(1);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hdl/order_book_matcher.sv
// The book engine works through a request by scanning a book one slot a cycle
//   while its output is not busy, and shifts the book to insert or remove an entry.
// Throughput: one request at a time in the engine; a two-entry queue in
//   front keeps taking requests while the engine works.
// Results leave through a one-entry output register, one per cycle at most.
// Reset (rst, synchronous): both books empty, order id counter at zero.
module order_book_matcher import obm_pkg::*; #(
  parameter int SIDE_DEPTH = SIDE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic q_valid, q_ready;
  req_t q_req;

  // front: request queue
  obm_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_req(in_data),
    .q_valid, .q_ready, .q_req
  );

  // back: matching engine and books
  obm_back #(.SIDE_DEPTH(SIDE_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_req,
    .res_valid(out_valid), .res_ready(out_ready), .res(out_data)
  );

endmodule

FILE: tb/obm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obm_checker: result checker for the order book matcher
// Watches both channels, keeps its own copy of the books, predicts the
// result stream of every accepted request and compares it in order.
// ----------------------------------------------------------------------------
module obm_checker import obm_pkg::*; #(
  parameter int DEPTH = SIDE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  res_t out_data,
  output int   fail_count,
  output int   pending
);

  slot_t bids[$];
  slot_t asks[$];
  logic [15:0] id_ctr;
  res_t  due_q[$];

  assign pending = due_q.size();

  function automatic res_t mk(kind_t k, logic [15:0] oid, logic [15:0] oth,
                              logic [13:0] code, logic [16:0] p2,
                              logic [15:0] q, logic sd);
    res_t r;
    r.kind = k; r.order_id = oid; r.other_id = oth; r.code_out = code;
    r.price_twice = p2; r.qty_out = q; r.side_out = sd; r.last = 1'b0;
    return r;
  endfunction

  // insert keeping price priority; equal prices stay behind earlier ones
  function automatic void rest_order(ref slot_t bk[$], input slot_t s, input logic desc);
    int pos;
    pos = 0;
    while (pos < bk.size()) begin
      if (desc ? (s.price > bk[pos].price) : (s.price < bk[pos].price)) break;
      pos++;
    end
    bk.insert(pos, s);
  endfunction

  task automatic match_request(input req_t rq);
    res_t  outs[$];
    slot_t s;
    logic [15:0] oid;
    logic [15:0] rem;
    logic [15:0] q;
    int i;
    logic hit;
    case (func_t'(rq.func))
      FN_SUBMIT: begin
        oid = (id_ctr == 16'hFFFF) ? 16'd1 : id_ctr + 16'd1;
        id_ctr = oid;
        rem = rq.order_qty;
        outs.push_back(mk(K_ID, oid, 0, rq.stock_code, {rq.limit_price, 1'b0},
                          rq.order_qty, rq.is_sell));
        i = 0;
        if (rq.is_sell) begin
          while (rem > 0 && i < bids.size()) begin
            if (bids[i].code == rq.stock_code && bids[i].price >= rq.limit_price) begin
              q = (bids[i].qty < rem) ? bids[i].qty : rem;
              outs.push_back(mk(K_DEAL, bids[i].id, oid, rq.stock_code,
                                17'(bids[i].price) + 17'(rq.limit_price), q, 1'b0));
              bids[i].qty -= q; rem -= q;
              if (bids[i].qty == 0) bids.delete(i); else i++;
            end else i++;
          end
        end else begin
          while (rem > 0 && i < asks.size()) begin
            if (asks[i].code == rq.stock_code && asks[i].price <= rq.limit_price) begin
              q = (asks[i].qty < rem) ? asks[i].qty : rem;
              outs.push_back(mk(K_DEAL, oid, asks[i].id, rq.stock_code,
                                17'(asks[i].price) + 17'(rq.limit_price), q, 1'b0));
              asks[i].qty -= q; rem -= q;
              if (asks[i].qty == 0) asks.delete(i); else i++;
            end else i++;
          end
        end
        if (rem > 0) begin
          s.id = oid; s.code = rq.stock_code; s.price = rq.limit_price; s.qty = rem;
          if (rq.is_sell && asks.size() < DEPTH) rest_order(asks, s, 1'b0);
          else if (!rq.is_sell && bids.size() < DEPTH) rest_order(bids, s, 1'b1);
          else outs.push_back(mk(K_FULL, oid, 0, rq.stock_code,
                                 {rq.limit_price, 1'b0}, rem, rq.is_sell));
        end
      end
      FN_QUERY: begin
        foreach (bids[j])
          if (bids[j].code == rq.stock_code)
            outs.push_back(mk(K_LBUY, bids[j].id, 0, rq.stock_code,
                              {bids[j].price, 1'b0}, bids[j].qty, 1'b0));
        foreach (asks[j])
          if (asks[j].code == rq.stock_code)
            outs.push_back(mk(K_LSELL, asks[j].id, 0, rq.stock_code,
                              {asks[j].price, 1'b0}, asks[j].qty, 1'b1));
      end
      FN_CANCEL: begin
        hit = 1'b0;
        // buy book wins when a wrapped id is live twice
        for (i = 0; i < bids.size() && !hit; i++)
          if (bids[i].id == rq.cancel_id) begin
            outs.push_back(mk(K_CANCEL, bids[i].id, 0, bids[i].code,
                              {bids[i].price, 1'b0}, bids[i].qty, 1'b0));
            bids.delete(i); hit = 1'b1;
          end
        for (i = 0; i < asks.size() && !hit; i++)
          if (asks[i].id == rq.cancel_id) begin
            outs.push_back(mk(K_CANCEL, asks[i].id, 0, asks[i].code,
                              {asks[i].price, 1'b0}, asks[i].qty, 1'b1));
            asks.delete(i); hit = 1'b1;
          end
        if (!hit) outs.push_back(mk(K_NOTFND, rq.cancel_id, 0, 0, 0, 0, 1'b0));
      end
      default: ;
    endcase
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[j]) due_q.push_back(outs[j]);
  endtask

  task automatic cmp(input string nm, input int e, input int a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", nm, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      bids.delete(); asks.delete(); due_q.delete();
      id_ctr = 0; fail_count = 0;
    end else begin
      // results first: a request accepted now cannot produce one this edge
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result kind %0d id %0d", out_data.kind, out_data.order_id);
          fail_count++;
        end else begin
          e = due_q.pop_front();
          cmp("kind", e.kind, out_data.kind);
          cmp("order_id", e.order_id, out_data.order_id);
          cmp("other_id", e.other_id, out_data.other_id);
          cmp("code_out", e.code_out, out_data.code_out);
          cmp("price_twice", e.price_twice, out_data.price_twice);
          cmp("qty_out", e.qty_out, out_data.qty_out);
          cmp("side_out", e.side_out, out_data.side_out);
          cmp("last", e.last, out_data.last);
        end
      end
      if (in_valid && in_ready) match_request(in_data);
    end
  end

endmodule

FILE: tb/tb_order_book_matcher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_order_book_matcher: stimulus and verdict for the order book matcher
// Directed corner requests, then random trading on a few stock codes with
// random idle bursts on both channels; a side checker predicts every result.
// ----------------------------------------------------------------------------
module tb_order_book_matcher;
  import obm_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  res_t out_data;
  int   fail_count;
  int   pending;
  bit   quiet;       // no idling near the end of the run
  bit   drained;

  order_book_matcher i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  obm_checker i_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: well above 415 requests * worst engine time and stalls
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stall bursts, none once quiet is set.
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Present one request and hold it until accepted. Sender gaps go before it.
  task automatic send_req(input req_t rq);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic submit(input logic sell, input logic [13:0] code,
                        input logic [15:0] price, input logic [15:0] qty);
    req_t rq;
    rq = '0;
    rq.func = FN_SUBMIT; rq.is_sell = sell; rq.stock_code = code;
    rq.limit_price = price; rq.order_qty = qty;
    rq.cancel_id = 16'($urandom);
    send_req(rq);
  endtask

  task automatic ask_code(input func_t f, input logic [13:0] code,
                          input logic [15:0] cid);
    req_t rq;
    rq = req_t'({$urandom, $urandom, $urandom});
    rq.func = f; rq.stock_code = code; rq.cancel_id = cid;
    send_req(rq);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    req_t rq;
    int   r;
    int   issued;
    logic [13:0] codes[4];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    quiet = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: cancel of id zero and of an unknown id, empty query
    ask_code(FN_CANCEL, 0, 16'd0);
    ask_code(FN_CANCEL, 0, 16'hFFFF);
    ask_code(FN_QUERY, 14'h3FFF, 0);
    // field extremes, zero quantity, codes above 9999
    submit(1'b0, 14'h3FFF, 16'hFFFF, 16'hFFFF);
    submit(1'b1, 14'h3FFF, 16'd0, 16'd1);
    submit(1'b1, 14'd9999, 16'd0, 16'd0);
    // equal prices keep arrival order, partial and full fills
    submit(1'b1, 14'd5, 16'd100, 16'd10);
    submit(1'b1, 14'd5, 16'd100, 16'd20);
    submit(1'b1, 14'd5, 16'd90, 16'd5);
    submit(1'b0, 14'd5, 16'd100, 16'd25);
    ask_code(FN_QUERY, 14'd5, 0);
    ask_code(FN_CANCEL, 0, 16'd8);
    ask_code(FN_QUERY, 14'd5, 0);
    ask_code(FN_QUERY, 14'h3FFF, 0);
    rq = req_t'({$urandom, $urandom, $urandom});
    rq.func = FN_NONE;
    send_req(rq);
    // fill the sell book, then overflow it
    for (int k = 0; k < 18; k++) submit(1'b1, 14'd7, 16'(200 + k), 16'd3);
    ask_code(FN_QUERY, 14'd7, 0);
    submit(1'b0, 14'd7, 16'hFFFF, 16'hFFFF);
    wait_drain();

    // random trading on a small code set so orders meet
    for (int k = 0; k < 4; k++) codes[k] = 14'($urandom_range(0, 9999));
    codes[3] = 14'h3FFF;
    issued = 0;
    while (issued < 380) begin
      if (issued == 330) quiet = 1'b1;
      if (issued == 150) wait_drain();
      r = $urandom_range(0, 99);
      if (r < 60) begin
        submit($urandom_range(0, 1), codes[$urandom_range(0, 3)],
               16'($urandom_range(0, 15) == 0 ? $urandom : 1000 + $urandom_range(0, 20)),
               16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 40)));
      end else if (r < 75) begin
        ask_code(FN_QUERY, $urandom_range(0, 7) == 0 ? 14'($urandom)
                 : codes[$urandom_range(0, 3)], 0);
      end else if (r < 95) begin
        ask_code(FN_CANCEL, 0, $urandom_range(0, 7) == 0 ? 16'($urandom)
                 : 16'($urandom_range(1, 20 + issued)));
      end else begin
        send_req(req_t'({$urandom, $urandom, $urandom}));
      end
      issued++;
    end
    wait_drain();
    repeat (50) @(posedge clk);
    drained = (pending == 0);
    if (fail_count == 0 && drained) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/obm_pkg.sv
hdl/obm_front.sv
hdl/obm_back.sv
hdl/order_book_matcher.sv
tb/obm_checker.sv
tb/tb_order_book_matcher.sv
